[src/kalman_filter_2state_cv_core_assert.svh]
// Assertion macros for the Kalman core
`ifndef KALMAN_FILTER_2STATE_CV_CORE_ASSERT_SVH
`define KALMAN_FILTER_2STATE_CV_CORE_ASSERT_SVH

// implication checked at every edge outside reset
`define KF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the antecedent
`define KF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/kf2cv_pkg.sv]
`default_nettype none
package kf2cv_pkg;
	localparam int FracBits = 24;
	localparam int VW = 48;
	localparam int DtW = 25;
	localparam int NoiseW = 47;
	localparam int CfgW = 47;
	localparam int CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_TIME_STEP = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_QP = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_QV = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_RP = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_RV = 3'd4;

	// datapath operations
	typedef enum logic [2:0] {
		OP_NOP,
		OP_MUL,
		OP_ADD,
		OP_SUB,
		OP_DIV,
		OP_MOV
	} op_t;

	// register file slots
	localparam int NREG = 32;
	localparam int RW = 5;
	localparam logic [RW-1:0] R_SX = 5'd0, R_SV = 5'd1, R_PP = 5'd2, R_PV = 5'd3,
		R_VV = 5'd4, R_DT = 5'd5, R_QP = 5'd6, R_QV = 5'd7, R_RP = 5'd8, R_RV = 5'd9,
		R_Z0 = 5'd10, R_Z1 = 5'd11, R_XP0 = 5'd12, R_T = 5'd13, R_P11 = 5'd14,
		R_P22 = 5'd15, R_S11 = 5'd16, R_S22 = 5'd17, R_DET = 5'd18, R_K11 = 5'd19,
		R_K12 = 5'd20, R_K21 = 5'd21, R_K22 = 5'd22, R_Y0 = 5'd23, R_Y1 = 5'd24,
		R_M11 = 5'd25, R_M12 = 5'd26, R_M21 = 5'd27, R_M22 = 5'd28, R_A = 5'd29,
		R_B = 5'd30, R_ZERO = 5'd31;

	typedef struct packed {
		op_t op;
		logic [RW-1:0] src_a;
		logic [RW-1:0] src_b;
		logic [RW-1:0] dst;
	} instr_t;

	localparam int NPROG = 52;
	localparam int PCW = 6;

	function automatic instr_t ins(op_t o, logic [RW-1:0] d, logic [RW-1:0] a,
			logic [RW-1:0] b);
		instr_t r;
		r.op = o; r.dst = d; r.src_a = a; r.src_b = b;
		return r;
	endfunction

	// microprogram; the four gain divides sit at 27..30 and are skipped on det zero
	function automatic instr_t prog(logic [PCW-1:0] pc);
		instr_t r;
		r = ins(OP_NOP, R_ZERO, R_ZERO, R_ZERO);
		unique case (pc)
			6'd0: r = ins(OP_MUL, R_A, R_DT, R_SV);
			6'd1: r = ins(OP_ADD, R_XP0, R_SX, R_A);
			6'd2: r = ins(OP_MUL, R_A, R_DT, R_VV);
			6'd3: r = ins(OP_ADD, R_T, R_PV, R_A);
			6'd4: r = ins(OP_MUL, R_A, R_DT, R_PV);
			6'd5: r = ins(OP_ADD, R_P11, R_PP, R_A);
			6'd6: r = ins(OP_MUL, R_A, R_DT, R_T);
			6'd7: r = ins(OP_ADD, R_P11, R_P11, R_A);
			6'd8: r = ins(OP_ADD, R_P11, R_P11, R_QP);
			6'd9: r = ins(OP_ADD, R_P22, R_VV, R_QV);
			6'd10: r = ins(OP_ADD, R_S11, R_P11, R_RP);
			6'd11: r = ins(OP_ADD, R_S22, R_P22, R_RV);
			6'd12: r = ins(OP_MUL, R_A, R_S11, R_S22);
			6'd13: r = ins(OP_MUL, R_B, R_T, R_T);
			6'd14: r = ins(OP_SUB, R_DET, R_A, R_B);
			6'd15: r = ins(OP_MUL, R_A, R_P11, R_S22);
			6'd16: r = ins(OP_MUL, R_B, R_T, R_T);
			6'd17: r = ins(OP_SUB, R_K11, R_A, R_B);
			6'd18: r = ins(OP_MUL, R_A, R_T, R_S11);
			6'd19: r = ins(OP_MUL, R_B, R_P11, R_T);
			6'd20: r = ins(OP_SUB, R_K12, R_A, R_B);
			6'd21: r = ins(OP_MUL, R_A, R_T, R_S22);
			6'd22: r = ins(OP_MUL, R_B, R_P22, R_T);
			6'd23: r = ins(OP_SUB, R_K21, R_A, R_B);
			6'd24: r = ins(OP_MUL, R_A, R_P22, R_S11);
			6'd25: r = ins(OP_MUL, R_B, R_T, R_T);
			6'd26: r = ins(OP_SUB, R_K22, R_A, R_B);
			6'd27: r = ins(OP_DIV, R_K11, R_K11, R_DET);
			6'd28: r = ins(OP_DIV, R_K12, R_K12, R_DET);
			6'd29: r = ins(OP_DIV, R_K21, R_K21, R_DET);
			6'd30: r = ins(OP_DIV, R_K22, R_K22, R_DET);
			6'd31: r = ins(OP_SUB, R_Y0, R_Z0, R_XP0);
			6'd32: r = ins(OP_SUB, R_Y1, R_Z1, R_SV);
			6'd33: r = ins(OP_MUL, R_A, R_K11, R_Y0);
			6'd34: r = ins(OP_ADD, R_A, R_XP0, R_A);
			6'd35: r = ins(OP_MUL, R_B, R_K12, R_Y1);
			6'd36: r = ins(OP_ADD, R_SX, R_A, R_B);
			6'd37: r = ins(OP_MUL, R_A, R_K21, R_Y0);
			6'd38: r = ins(OP_ADD, R_A, R_SV, R_A);
			6'd39: r = ins(OP_MUL, R_B, R_K22, R_Y1);
			6'd40: r = ins(OP_ADD, R_SV, R_A, R_B);
			default: r = ins(OP_NOP, R_ZERO, R_ZERO, R_ZERO);
		endcase
		return r;
	endfunction

	// covariance-update program, second bank
	function automatic instr_t prog2(logic [PCW-1:0] pc);
		instr_t r;
		r = ins(OP_NOP, R_ZERO, R_ZERO, R_ZERO);
		unique case (pc)
			6'd0: r = ins(OP_MUL, R_A, R_K11, R_S11);
			6'd1: r = ins(OP_MUL, R_B, R_K12, R_T);
			6'd2: r = ins(OP_ADD, R_M11, R_A, R_B);
			6'd3: r = ins(OP_MUL, R_A, R_K11, R_T);
			6'd4: r = ins(OP_MUL, R_B, R_K12, R_S22);
			6'd5: r = ins(OP_ADD, R_M12, R_A, R_B);
			6'd6: r = ins(OP_MUL, R_A, R_K21, R_S11);
			6'd7: r = ins(OP_MUL, R_B, R_K22, R_T);
			6'd8: r = ins(OP_ADD, R_M21, R_A, R_B);
			6'd9: r = ins(OP_MUL, R_A, R_K21, R_T);
			6'd10: r = ins(OP_MUL, R_B, R_K22, R_S22);
			6'd11: r = ins(OP_ADD, R_M22, R_A, R_B);
			6'd12: r = ins(OP_MUL, R_A, R_M11, R_K11);
			6'd13: r = ins(OP_MUL, R_B, R_M12, R_K12);
			6'd14: r = ins(OP_ADD, R_A, R_A, R_B);
			6'd15: r = ins(OP_SUB, R_PP, R_P11, R_A);
			6'd16: r = ins(OP_MUL, R_A, R_M11, R_K21);
			6'd17: r = ins(OP_MUL, R_B, R_M12, R_K22);
			6'd18: r = ins(OP_ADD, R_A, R_A, R_B);
			6'd19: r = ins(OP_SUB, R_PV, R_T, R_A);
			6'd20: r = ins(OP_MUL, R_A, R_M21, R_K21);
			6'd21: r = ins(OP_MUL, R_B, R_M22, R_K22);
			6'd22: r = ins(OP_ADD, R_A, R_A, R_B);
			6'd23: r = ins(OP_SUB, R_VV, R_P22, R_A);
			default: r = ins(OP_NOP, R_ZERO, R_ZERO, R_ZERO);
		endcase
		return r;
	endfunction

	localparam logic [PCW-1:0] LAST1 = 6'd40;
	localparam logic [PCW-1:0] LAST2 = 6'd23;
	localparam logic [PCW-1:0] FIRST_DIV = 6'd27;
	localparam logic [PCW-1:0] LAST_DIV = 6'd30;
	localparam logic [PCW-1:0] DET_PC = 6'd14;

	typedef struct packed {
		logic issue;
		instr_t ins;
		logic load_in;
		logic clr_sat;
		logic zero_k;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic det_zero;
	} dp_sts_t;
endpackage
`default_nettype wire

[src/kf2cv_if.sv]
`default_nettype none
interface kf2cv_meas_if;
	logic valid;
	logic ready;
	logic signed [47:0] meas_pos;
	logic signed [47:0] meas_vel;
	modport source (output valid, meas_pos, meas_vel, input ready);
	modport sink (input valid, meas_pos, meas_vel, output ready);
endinterface

interface kf2cv_est_if;
	logic valid;
	logic ready;
	logic signed [47:0] est_pos;
	logic signed [47:0] est_vel;
	logic saturated;
	modport source (output valid, est_pos, est_vel, saturated, input ready);
	modport sink (input valid, est_pos, est_vel, saturated, output ready);
endinterface
`default_nettype wire

[src/kalman_filter_2state_cv_core.sv]
// channel   | dir | payload
// meas      | in  | meas_pos, meas_vel (Q24.24 signed)
// est       | out | est_pos, est_vel, saturated
// cfg       | in  | cfg_we, cfg_idx, cfg_data (write only)
// One measurement transaction at a time; the estimate is captured in the output
// register once the microprogram is through: four gain divides (skipped when the
// determinant is zero), 32 multiplies and 29 add/sub steps.
// A new measurement is not taken until the last estimate has been captured.
// Reset (arst_n low) restores state, covariance, time step and default noise registers.
// A result waits in the output register; the next transaction is taken once
// it has left or while it leaves.
`default_nettype none
`include "kalman_filter_2state_cv_core_assert.svh"
module kalman_filter_2state_cv_core #(
	parameter int FRAC_BITS = kf2cv_pkg::FracBits
) (
	input wire logic clk,
	input wire logic arst_n,
	kf2cv_meas_if.sink meas,
	kf2cv_est_if.source est,
	input wire logic cfg_we,
	input wire logic [kf2cv_pkg::CfgIdxW-1:0] cfg_idx,
	input wire logic [kf2cv_pkg::CfgW-1:0] cfg_data
);
	import kf2cv_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic capture;
	logic signed [VW-1:0] x_pos, x_vel;
	logic sat;
	logic signed [VW-1:0] pos_q, vel_q;
	logic sat_q;

	kf2cv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(meas.valid), .in_ready(meas.ready),
		.out_valid(est.valid), .out_ready(est.ready),
		.cmd(cmd), .sts(sts), .capture(capture)
	);

	kf2cv_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.z_pos(meas.meas_pos), .z_vel(meas.meas_vel),
		.x_pos(x_pos), .x_vel(x_vel), .sat(sat)
	);

	// output register holds the transaction until taken
	always_ff @(posedge clk) begin
		if (capture) begin
			pos_q <= x_pos;
			vel_q <= x_vel;
			sat_q <= sat;
		end
	end

	assign est.est_pos = pos_q;
	assign est.est_vel = vel_q;
	assign est.saturated = sat_q;

	`KF_ASSERT_IMP(a_no_accept_busy, clk, arst_n, meas.valid && meas.ready, !capture,
		"input taken while a result is being captured")
	`KF_ASSERT_NEXT(a_capture_valid, clk, arst_n, capture, est.valid,
		"captured result not presented")
endmodule
`default_nettype wire

[src/kf2cv_divider.sv]
`default_nettype none
// Restoring divider: |n|*2^F / |d|, one quotient bit a cycle, rounded and clamped
module kf2cv_divider #(
	parameter int FRAC_BITS = kf2cv_pkg::FracBits
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [kf2cv_pkg::VW-1:0] num,
	input wire logic signed [kf2cv_pkg::VW-1:0] den,
	output logic done,
	output logic signed [kf2cv_pkg::VW-1:0] quo,
	output logic clamp
);
	import kf2cv_pkg::*;
	localparam int NW = VW + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] n_q, q_q;
	logic [VW:0] rem_q;
	logic [VW-1:0] d_q;
	logic neg_q, run_q;
	logic [CW-1:0] cnt_q;
	logic [VW:0] rem_sh;
	logic [VW:0] d_ext;
	logic [NW:0] qr;
	logic [VW-1:0] lim;
	logic over;

	assign rem_sh = {rem_q[VW-1:0], n_q[NW-1]};
	assign d_ext = {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= {(num[VW-1] ? VW'(-num) : VW'(num)), FRAC_BITS'(0)};
			d_q <= den[VW-1] ? VW'(-den) : VW'(den);
			neg_q <= num[VW-1] ^ den[VW-1];
			rem_q <= '0;
			q_q <= '0;
		end else if (run_q) begin
			n_q <= n_q << 1;
			if (rem_sh >= d_ext) begin
				rem_q <= rem_sh - d_ext;
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		qr = {1'b0, q_q} + (({rem_q, 1'b0} >= {1'b0, d_ext}) ? (NW+1)'(1) : '0);
		lim = neg_q ? VW'(48'h8000_0000_0000) : VW'(48'h7FFF_FFFF_FFFF);
		over = (qr > (NW+1)'(lim));
		clamp = over;
		if (over) quo = neg_q ? $signed(lim) : $signed(lim);
		else quo = neg_q ? VW'(-$signed(qr[VW-1:0])) : $signed(qr[VW-1:0]);
	end
endmodule
`default_nettype wire

[src/kf2cv_datapath.sv]
`default_nettype none
// Register file, saturating multiplier/adder and divider
module kf2cv_datapath #(
	parameter int FRAC_BITS = kf2cv_pkg::FracBits
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire kf2cv_pkg::dp_cmd_t cmd,
	output kf2cv_pkg::dp_sts_t sts,
	input wire logic cfg_we,
	input wire logic [kf2cv_pkg::CfgIdxW-1:0] cfg_idx,
	input wire logic [kf2cv_pkg::CfgW-1:0] cfg_data,
	input wire logic signed [kf2cv_pkg::VW-1:0] z_pos,
	input wire logic signed [kf2cv_pkg::VW-1:0] z_vel,
	output logic signed [kf2cv_pkg::VW-1:0] x_pos,
	output logic signed [kf2cv_pkg::VW-1:0] x_vel,
	output logic sat
);
	import kf2cv_pkg::*;
	localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic signed [VW-1:0] ONE = VW'(1) << FRAC_BITS;
	localparam int HW = VW / 2;
	localparam logic [2:0] MUL_STEPS = 3'd4;

	logic signed [VW-1:0] rf_q [NREG];
	logic sat_q;
	logic signed [VW-1:0] a, b, res;
	logic signed [VW:0] sum;
	logic [2*VW:0] prod_rnd;
	logic [VW-1:0] ma, mb;
	logic res_clamp;
	logic div_start, div_done, div_clamp, div_busy_q;
	logic signed [VW-1:0] div_quo;
	logic [RW-1:0] div_dst_q;
	logic mul_start, mul_busy_q;
	logic [2:0] mul_cnt_q;
	logic [VW-1:0] ma_q, mb_q;
	logic pneg_q;
	logic [RW-1:0] mul_dst_q;
	logic [2*VW-1:0] acc_q;
	logic [HW-1:0] pa, pb;
	logic [2*HW-1:0] pp;
	logic [2*VW-1:0] pp_sh;

	// reset contents: filter state and default settings
	function automatic logic signed [VW-1:0] rf_rst(logic [RW-1:0] r);
		logic signed [VW-1:0] v;
		unique case (r)
			R_PP: v = ONE * 1000;
			R_VV: v = ONE * 1000;
			R_DT: v = VW'(((longint'(1) << FRAC_BITS) * 2 + 50) / 100);
			R_QP: v = VW'(((longint'(1) << FRAC_BITS) * 2 + 500000) / 1000000);
			R_QV: v = VW'(((longint'(1) << FRAC_BITS) + 5000) / 10000);
			R_RP: v = ONE;
			R_RV: v = ONE;
			default: v = '0;
		endcase
		return v;
	endfunction

	assign a = rf_q[cmd.ins.src_a];
	assign b = rf_q[cmd.ins.src_b];
	assign ma = a[VW-1] ? VW'(-a) : VW'(a);
	assign mb = b[VW-1] ? VW'(-b) : VW'(b);
	assign div_start = cmd.issue && (cmd.ins.op == OP_DIV);
	assign mul_start = cmd.issue && (cmd.ins.op == OP_MUL);

	kf2cv_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(a), .den(b),
		.done(div_done), .quo(div_quo), .clamp(div_clamp)
	);

	// product of magnitudes from four half-width partial products, one a cycle
	always_comb begin
		unique case (mul_cnt_q)
			3'd4: begin
				pa = ma_q[HW-1:0];
				pb = mb_q[HW-1:0];
			end
			3'd3: begin
				pa = ma_q[HW-1:0];
				pb = mb_q[VW-1:HW];
			end
			3'd2: begin
				pa = ma_q[VW-1:HW];
				pb = mb_q[HW-1:0];
			end
			default: begin
				pa = ma_q[VW-1:HW];
				pb = mb_q[VW-1:HW];
			end
		endcase
		pp = pa * pb;
		unique case (mul_cnt_q)
			3'd4: pp_sh = (2*VW)'(pp);
			3'd3, 3'd2: pp_sh = (2*VW)'(pp) << HW;
			default: pp_sh = (2*VW)'(pp) << (2*HW);
		endcase
	end

	always_comb begin
		prod_rnd = {1'b0, acc_q} + ((2*VW+1)'(1) << (FRAC_BITS - 1));
		prod_rnd = prod_rnd >> FRAC_BITS;
		res_clamp = 1'b0;
		sum = '0;
		res = '0;
		if (mul_busy_q) begin
			if (prod_rnd > (2*VW+1)'(pneg_q ? {1'b0, VMIN} : {1'b0, VMAX})) begin
				res_clamp = 1'b1;
				res = pneg_q ? VMIN : VMAX;
			end else begin
				res = pneg_q ? VW'(-$signed(prod_rnd[VW-1:0])) : $signed(prod_rnd[VW-1:0]);
			end
		end else begin
			unique case (cmd.ins.op)
				OP_ADD: sum = {a[VW-1], a} + {b[VW-1], b};
				OP_SUB: sum = {a[VW-1], a} - {b[VW-1], b};
				default: sum = {a[VW-1], a};
			endcase
			if (sum[VW] != sum[VW-1]) begin
				res_clamp = (cmd.ins.op == OP_ADD) || (cmd.ins.op == OP_SUB);
				res = sum[VW] ? VMIN : VMAX;
			end else begin
				res = sum[VW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_start) begin
			ma_q <= ma;
			mb_q <= mb;
			pneg_q <= a[VW-1] ^ b[VW-1];
			mul_dst_q <= cmd.ins.dst;
			acc_q <= '0;
		end else if (mul_cnt_q != 3'd0) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREG; i++) rf_q[i] <= rf_rst(RW'(i));
			sat_q <= 1'b0;
			mul_busy_q <= 1'b0;
			mul_cnt_q <= '0;
			div_busy_q <= 1'b0;
			div_dst_q <= '0;
		end else begin
			mul_busy_q <= (mul_cnt_q == 3'd1);
			if (mul_start) mul_cnt_q <= MUL_STEPS;
			else if (mul_cnt_q != 3'd0) mul_cnt_q <= mul_cnt_q - 3'd1;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_TIME_STEP: rf_q[R_DT] <= VW'(cfg_data[DtW-1:0]);
					REG_QP: rf_q[R_QP] <= VW'(cfg_data[NoiseW-1:0]);
					REG_QV: rf_q[R_QV] <= VW'(cfg_data[NoiseW-1:0]);
					REG_RP: rf_q[R_RP] <= VW'(cfg_data[NoiseW-1:0]);
					REG_RV: rf_q[R_RV] <= VW'(cfg_data[NoiseW-1:0]);
					default: ;
				endcase
			end
			if (cmd.load_in) begin
				rf_q[R_Z0] <= z_pos;
				rf_q[R_Z1] <= z_vel;
			end
			if (cmd.clr_sat) sat_q <= 1'b0;
			if (cmd.zero_k) begin
				rf_q[R_K11] <= '0; rf_q[R_K12] <= '0;
				rf_q[R_K21] <= '0; rf_q[R_K22] <= '0;
				sat_q <= 1'b1;
			end
			if (mul_busy_q) begin
				rf_q[mul_dst_q] <= res;
				if (res_clamp) sat_q <= 1'b1;
			end else if (cmd.issue && (cmd.ins.op == OP_ADD || cmd.ins.op == OP_SUB
					|| cmd.ins.op == OP_MOV)) begin
				rf_q[cmd.ins.dst] <= res;
				if (res_clamp) sat_q <= 1'b1;
			end
			if (div_start) begin
				div_busy_q <= 1'b1;
				div_dst_q <= cmd.ins.dst;
			end
			if (div_done) begin
				div_busy_q <= 1'b0;
				rf_q[div_dst_q] <= div_quo;
				if (div_clamp) sat_q <= 1'b1;
			end
		end
	end

	assign sts.busy = mul_busy_q || (mul_cnt_q != 3'd0) || div_busy_q;
	assign sts.det_zero = (rf_q[R_DET] == '0);
	assign x_pos = rf_q[R_SX];
	assign x_vel = rf_q[R_SV];
	assign sat = sat_q;
endmodule
`default_nettype wire

[src/kf2cv_ctrl.sv]
`default_nettype none
// Sequencer: steps through the microprogram, waits on multi-cycle operations
module kf2cv_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	output kf2cv_pkg::dp_cmd_t cmd,
	input wire kf2cv_pkg::dp_sts_t sts,
	output logic capture
);
	import kf2cv_pkg::*;
	localparam logic [2:0] S_IDLE = 3'd0, S_RUN1 = 3'd1, S_WAIT1 = 3'd2,
		S_RUN2 = 3'd3, S_WAIT2 = 3'd4, S_DONE = 3'd5;

	logic [2:0] state_q, state_d;
	logic [PCW-1:0] pc_q, pc_d;
	logic out_valid_q;
	logic start, busy;

	assign start = in_valid && in_ready;
	assign busy = sts.busy;
	assign in_ready = (state_q == S_IDLE) && !(out_valid_q && !out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		pc_d = pc_q;
		cmd = '0;
		capture = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_in = 1'b1;
					cmd.clr_sat = 1'b1;
					state_d = S_RUN1;
					pc_d = '0;
				end
			end
			S_RUN1: begin
				if (pc_q == FIRST_DIV && sts.det_zero) begin
					cmd.zero_k = 1'b1;
					pc_d = LAST_DIV + 1'b1;
				end else begin
					cmd.issue = 1'b1;
					cmd.ins = prog(pc_q);
					state_d = (cmd.ins.op == OP_MUL || cmd.ins.op == OP_DIV) ? S_WAIT1 : S_RUN1;
					if (pc_q == LAST1) begin
						state_d = S_RUN2;
						pc_d = '0;
					end else begin
						pc_d = pc_q + 1'b1;
					end
				end
			end
			S_WAIT1: if (!busy) state_d = S_RUN1;
			S_RUN2: begin
				cmd.issue = 1'b1;
				cmd.ins = prog2(pc_q);
				state_d = (cmd.ins.op == OP_MUL) ? S_WAIT2 : S_RUN2;
				if (pc_q == LAST2) state_d = S_DONE;
				else pc_d = pc_q + 1'b1;
			end
			S_WAIT2: if (!busy) state_d = S_RUN2;
			S_DONE: if (!busy) begin
				capture = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q <= pc_d;
			if (capture) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

[verif/tb_top.sv]
`default_nettype none
module tb_top;
	import kf2cv_pkg::*;

	// register indexes past the last real one; writes there must be dropped
	localparam logic [CfgIdxW-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_SPARE_LAST = 3'd7;

	localparam longint VMAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint VMIN = -64'sh8000_0000_0000;
	localparam longint ONE = 64'sd1 <<< FracBits;
	localparam longint MASK47 = 64'sh7FFF_FFFF_FFFF;

	// reset values of the filter settings
	localparam longint DT_RST = 335544;
	localparam longint QP_RST = 34;
	localparam longint QV_RST = 1678;

	// drain allowance after the last estimate, and overall run limit
	localparam int SETTLE_CYCLES = 400;
	localparam longint RUN_LIMIT = 64'd12 * 64'd2_000_000;

	typedef struct {
		logic signed [VW-1:0] pos;
		logic signed [VW-1:0] vel;
		logic sat;
	} estimate_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_idx;
	logic [CfgW-1:0] cfg_data;

	kf2cv_meas_if meas ();
	kf2cv_est_if est ();

	kalman_filter_2state_cv_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.meas(meas.sink),
		.est(est.source),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// clock: 12 time units per period
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// --- filter model: own copy of settings, estimate and covariance ---
	longint dt_q, qp_q, qv_q, rp_q, rv_q;
	longint x_pos, x_vel, c_pp, c_pv, c_vv;
	bit clipped;

	estimate_t est_pending[$];
	int meas_sent, est_checked, sat_count, settings_used, mismatches;

	// stimulus knobs shared with the ready process
	bit idle_on;
	int hold_left;

	function automatic logic [63:0] mag(longint a);
		return (a < 0) ? -a : a;
	endfunction

	function automatic longint clamp48(longint v);
		if (v > VMAX) begin
			clipped = 1'b1;
			return VMAX;
		end
		if (v < VMIN) begin
			clipped = 1'b1;
			return VMIN;
		end
		return v;
	endfunction

	function automatic longint sadd(longint a, longint b);
		return clamp48(a + b);
	endfunction

	function automatic longint ssub(longint a, longint b);
		return clamp48(a - b);
	endfunction

	// magnitude to signed value, clamped to the 48-bit range
	function automatic longint pack_mag(logic [127:0] q, bit neg);
		logic [127:0] lim;
		lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 128'd1);
		if (q > lim) begin
			clipped = 1'b1;
			q = lim;
		end
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	// product rounded half away from zero on the magnitude
	function automatic longint smul(longint a, longint b);
		logic [127:0] p;
		p = 128'(mag(a)) * 128'(mag(b));
		p = p + (128'd1 << (FracBits - 1));
		return pack_mag(p >> FracBits, (a < 0) != (b < 0));
	endfunction

	// n / d in fixed point, d nonzero, rounded to nearest
	function automatic longint sdiv(longint n, longint d);
		logic [127:0] num, den, q, r;
		num = 128'(mag(n)) << FracBits;
		den = 128'(mag(d));
		q = num / den;
		r = num % den;
		if (r * 2 >= den)
			q = q + 128'd1;
		return pack_mag(q, (n < 0) != (d < 0));
	endfunction

	function automatic void filter_reset();
		dt_q = DT_RST;
		qp_q = QP_RST;
		qv_q = QV_RST;
		rp_q = ONE;
		rv_q = ONE;
		x_pos = 0;
		x_vel = 0;
		c_pp = 1000 * ONE;
		c_pv = 0;
		c_vv = 1000 * ONE;
	endfunction

	// one predict + update cycle of the tracker
	function automatic estimate_t kf_predict_update(longint zp, longint zv);
		longint xp0, xp1, p11, p12, p22, t, s11, s12, s22, det;
		longint k11, k12, k21, k22, y0, y1, m11, m12, m21, m22, c11, c12, c22;
		estimate_t r;
		clipped = 1'b0;
		k11 = 0; k12 = 0; k21 = 0; k22 = 0;
		xp0 = sadd(x_pos, smul(dt_q, x_vel));
		xp1 = x_vel;
		t = sadd(c_pv, smul(dt_q, c_vv));
		p11 = sadd(sadd(c_pp, smul(dt_q, c_pv)), smul(dt_q, t));
		p11 = sadd(p11, qp_q);
		p12 = t;
		p22 = sadd(c_vv, qv_q);
		s11 = sadd(p11, rp_q);
		s12 = p12;
		s22 = sadd(p22, rv_q);
		det = ssub(smul(s11, s22), smul(s12, s12));
		if (det == 0) begin
			// singular innovation: gain stays zero, prediction passes through
			clipped = 1'b1;
		end else begin
			k11 = sdiv(ssub(smul(p11, s22), smul(p12, s12)), det);
			k12 = sdiv(ssub(smul(p12, s11), smul(p11, s12)), det);
			k21 = sdiv(ssub(smul(p12, s22), smul(p22, s12)), det);
			k22 = sdiv(ssub(smul(p22, s11), smul(p12, s12)), det);
		end
		y0 = ssub(zp, xp0);
		y1 = ssub(zv, xp1);
		x_pos = sadd(sadd(xp0, smul(k11, y0)), smul(k12, y1));
		x_vel = sadd(sadd(xp1, smul(k21, y0)), smul(k22, y1));
		m11 = sadd(smul(k11, s11), smul(k12, s12));
		m12 = sadd(smul(k11, s12), smul(k12, s22));
		m21 = sadd(smul(k21, s11), smul(k22, s12));
		m22 = sadd(smul(k21, s12), smul(k22, s22));
		c11 = sadd(smul(m11, k11), smul(m12, k12));
		c12 = sadd(smul(m11, k21), smul(m12, k22));
		c22 = sadd(smul(m21, k21), smul(m22, k22));
		c_pp = ssub(p11, c11);
		c_pv = ssub(p12, c12);
		c_vv = ssub(p22, c22);
		r.pos = x_pos[VW-1:0];
		r.vel = x_vel[VW-1:0];
		r.sat = clipped;
		return r;
	endfunction

	// idle lengths: mostly short, now and then long
	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	function automatic longint rand_full();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return longint'($signed(v[VW-1:0]));
	endfunction

	// moderate values, magnitude up to 2^19 units
	function automatic longint rand_mod();
		return longint'($signed($urandom)) <<< $urandom_range(0, 12);
	endfunction

	// --- result side: ready with random stalls and a commanded hold-off ---
	initial begin
		int stall_left;
		stall_left = 0;
		est.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				est.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				est.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) < 3) begin
				stall_left = pick_gap() - 1;
				est.ready <= 1'b0;
			end else begin
				est.ready <= 1'b1;
			end
		end
	end

	// --- checker: every estimate transaction against the oldest prediction ---
	always @(posedge clk) begin
		estimate_t e;
		if (arst_n && est.valid && est.ready) begin
			if (est_pending.size() == 0) begin
				$error("estimate with nothing outstanding: pos %0d vel %0d",
					est.est_pos, est.est_vel);
				mismatches++;
			end else begin
				e = est_pending.pop_front();
				if (est.est_pos !== e.pos) begin
					$error("est_pos: expected %0d, got %0d", e.pos, est.est_pos);
					mismatches++;
				end
				if (est.est_vel !== e.vel) begin
					$error("est_vel: expected %0d, got %0d", e.vel, est.est_vel);
					mismatches++;
				end
				if (est.saturated !== e.sat) begin
					$error("saturated: expected %0b, got %0b", e.sat, est.saturated);
					mismatches++;
				end
				est_checked++;
				if (e.sat)
					sat_count++;
			end
		end
	end

	// --- sender ---
	// Called at a clock edge; returns at the edge where the transaction went in.
	// valid is left high so back-to-back measurements need no second write.
	task automatic send_meas(longint zp, longint zv);
		int g;
		estimate_t pred;
		g = (idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (g > 0) begin
			meas.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		meas.valid <= 1'b1;
		meas.meas_pos <= zp[VW-1:0];
		meas.meas_vel <= zv[VW-1:0];
		do @(posedge clk); while (!meas.ready);
		pred = kf_predict_update(longint'($signed(zp[VW-1:0])),
			longint'($signed(zv[VW-1:0])));
		est_pending.insert(est_pending.size(), pred);
		meas_sent++;
	endtask

	// drop valid and wait until every estimate is back
	task automatic drain();
		meas.valid <= 1'b0;
		while (est_pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TIME_STEP: dt_q = longint'(val[DtW-1:0]);
			REG_QP: qp_q = longint'(val) & MASK47;
			REG_QV: qv_q = longint'(val) & MASK47;
			REG_RP: rp_q = longint'(val) & MASK47;
			REG_RV: rv_q = longint'(val) & MASK47;
			default: ;
		endcase
	endtask

	task automatic set_filter(longint dt, longint qp, longint qv, longint rp, longint rv);
		drain();
		cfg_write(REG_TIME_STEP, CfgW'(dt));
		cfg_write(REG_QP, CfgW'(qp));
		cfg_write(REG_QV, CfgW'(qv));
		cfg_write(REG_RP, CfgW'(rp));
		cfg_write(REG_RV, CfgW'(rv));
		settings_used++;
	endtask

	// --- tests ---
	task automatic test_field_extremes();
		send_meas(0, 0);
		send_meas(VMAX, VMAX);
		send_meas(VMIN, VMIN);
		send_meas(VMAX, VMIN);
		send_meas(VMIN, VMAX);
		send_meas(ONE, -ONE);
		send_meas(-1, 1);
		send_meas(3 * ONE, ONE / 2);
	endtask

	task automatic test_setting_extremes();
		// no prediction step at all
		set_filter(0, QP_RST, QV_RST, ONE, ONE);
		send_meas(5 * ONE, 2 * ONE);
		send_meas(6 * ONE, 2 * ONE);
		// time step above one second, all 25 bits set
		set_filter(64'h1FF_FFFF, QP_RST, QV_RST, ONE, ONE);
		send_meas(100 * ONE, 50 * ONE);
		send_meas(VMAX, VMAX);
		send_meas(-ONE, -ONE);
		// largest noise everywhere: sums clamp
		set_filter(ONE, MASK47, MASK47, MASK47, MASK47);
		send_meas(ONE, ONE);
		send_meas(VMIN, VMAX);
		// no noise and no motion: covariance collapses, determinant goes to zero
		set_filter(0, 0, 0, 0, 0);
		repeat (4) send_meas(7 * ONE, -3 * ONE);
		// writes past the last register must change nothing
		drain();
		for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
			cfg_write(CfgIdxW'(i), CfgW'({$urandom, $urandom}));
		send_meas(ONE, ONE);
		set_filter(DT_RST, QP_RST, QV_RST, ONE, ONE);
	endtask

	// receiver holds off while measurements keep coming: input must stall
	task automatic test_backpressure();
		drain();
		@(posedge clk);
		hold_left = 1500;
		repeat (5) send_meas(rand_mod(), rand_mod());
		// sender waits out every estimate before going on
		drain();
		send_meas(rand_mod(), rand_mod());
	endtask

	// a constant-velocity track with measurement noise, plus stray items
	task automatic run_track(int n);
		longint tp, tv;
		tp = rand_mod();
		tv = longint'($signed($urandom)) >>> 4;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1: send_meas(rand_full(), rand_full());
				2: send_meas(rand_mod(), rand_mod());
				default: begin
					tp = tp + smul(dt_q, tv);
					send_meas(tp + ($signed($urandom_range(0, 65535)) - 32768) * 64,
						tv + ($signed($urandom_range(0, 65535)) - 32768) * 16);
				end
			endcase
		end
	endtask

	task automatic test_random();
		// defaults, with idling
		run_track(150);
		// stretch with no idling on either side
		drain();
		idle_on = 1'b0;
		run_track(60);
		idle_on = 1'b1;
		// random settings, small steps so the state stays in range
		set_filter($urandom_range(1, 1 << 22), $urandom_range(0, 1 << 16),
			$urandom_range(0, 1 << 20), $urandom_range(1 << 20, 1 << 28),
			$urandom_range(1 << 20, 1 << 28));
		run_track(140);
		// fully random settings
		set_filter({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
		run_track(80);
		set_filter(ONE, QP_RST, QV_RST, ONE / 4, 4 * ONE);
		run_track(140);
	endtask

	// --- run ---
	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_TIME_STEP;
		cfg_data <= '0;
		meas.valid <= 1'b0;
		meas.meas_pos <= '0;
		meas.meas_vel <= '0;
		idle_on = 1'b1;
		hold_left = 0;
		settings_used = 1;
		filter_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_setting_extremes();
		test_backpressure();
		test_random();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Ran %0d measurements through %0d filter settings;", meas_sent,
			settings_used);
		$display("%0d estimates checked, %0d of them flagged as clamped.", est_checked,
			sat_count);
		if (mismatches == 0 && est_pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// hard stop if the block hangs
	initial begin
		#(RUN_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire
